[design/set_assoc_lru_cache_model_macros.svh]
// Assertion shorthands shared by the checker files.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SALC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SALC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/salc_pkg.sv]
package salc_pkg;

  localparam int ADDRESS_BITS = 64;
  localparam int KIND_W       = 2;
  localparam int TOTAL_W      = 32;
  localparam int SIB_W        = 3;
  localparam int OFFSET_W     = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_INDEX_BITS = 2'd0,
    CFG_OFFSET_BITS    = 2'd1,
    CFG_WAYS_IN_USE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ADDRESS_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               eviction;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request
    logic read;     // split address, read set row
    logic commit;   // write back row, bump totals, load response
    logic clear;    // clear valid bits of one row
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // clearing the last row
    logic out_free;    // response register can take a new response
  } stat_t;

endpackage

[design/salc_ctrl.sv]
module salc_ctrl
  import salc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_free) state_next = req_valid ? ST_READ : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd         = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_WRITE: begin
        cmd.commit = stat.out_free;
        req_ready  = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    cmd.capture = req_valid && req_ready;
  end

endmodule

[design/salc_dp.sv]
module salc_dp
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  req_t                   req,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SH_W     = $clog2((1 << OFFSET_W) + MAX_SET_BITS);

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v,
                                                 input logic en);
    return (en && (v != '1)) ? v + TOTAL_W'(1) : v;
  endfunction

  // configuration
  logic [SIB_W-1:0]    set_index_bits;
  logic [OFFSET_W-1:0] offset_bits;
  logic [WAYS_W-1:0]   ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= '0;
      offset_bits    <= '0;
      ways_in_use    <= WAYS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[SIB_W-1:0];
        CFG_OFFSET_BITS:    offset_bits    <= cfg_data[OFFSET_W-1:0];
        CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [SB_W-1:0]   s_eff;
  logic [WCNT_W-1:0] ways_eff;

  assign s_eff = (32'(set_index_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                      : SB_W'(set_index_bits);
  assign ways_eff = (ways_in_use == '0)                ? WCNT_W'(1) :
                    (32'(ways_in_use) > MAX_WAYS)      ? WCNT_W'(MAX_WAYS) :
                                                         WCNT_W'(ways_in_use);

  // request register
  req_t req_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
  end

  // address split
  logic [ADDRESS_BITS-1:0] addr_sh;
  logic [SET_AW-1:0]       set_rd;
  logic [SH_W-1:0]         tag_shift;
  logic [ADDRESS_BITS-1:0] tag_rd;

  assign addr_sh   = req_q.address >> offset_bits;
  assign set_rd    = addr_sh[SET_AW-1:0] & ~({SET_AW{1'b1}} << s_eff);
  assign tag_shift = SH_W'(offset_bits) + SH_W'(s_eff);
  assign tag_rd    = req_q.address >> tag_shift;

  // clearing pass counter
  logic [SET_AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_AW'(1);
    end
  end

  assign stat.clear_last = (clr_cnt == SET_AW'(NUM_SETS - 1));
  assign stat.out_free   = !rsp_valid || rsp_ready;

  // set memories, one row per set
  logic [MAX_WAYS-1:0]                   valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] tag_mem   [NUM_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0]       rank_mem  [NUM_SETS];

  logic [MAX_WAYS-1:0]                   rd_valid;
  logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] rd_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0]       rd_rank;
  logic [SET_AW-1:0]                     set_q;
  logic [ADDRESS_BITS-1:0]               tag_q;

  logic [MAX_WAYS-1:0]                   new_valid;
  logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] new_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0]       new_rank;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem[clr_cnt] <= '0;
    end else if (cmd.commit) begin
      valid_mem[set_q] <= new_valid;
    end
    if (cmd.read) rd_valid <= valid_mem[set_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) tag_mem[set_q] <= new_tag;
    if (cmd.read) rd_tag <= tag_mem[set_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rank_mem[set_q] <= new_rank;
    if (cmd.read) rd_rank <= rank_mem[set_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      set_q <= set_rd;
      tag_q <= tag_rd;
    end
  end

  // lookup, replacement choice and LRU update
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] empty_vec;
  logic                found;
  logic                empty;
  logic [RANK_W-1:0]   hit_way;
  logic [RANK_W-1:0]   empty_way;
  logic [RANK_W-1:0]   victim_way;
  logic [RANK_W-1:0]   best_rank;
  logic [RANK_W-1:0]   way_sel;
  logic [RANK_W:0]     old_rank;
  logic                modify;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]    = (32'(i) < 32'(ways_eff));
      hit_vec[i]   = in_use[i] && rd_valid[i] && (rd_tag[i] == tag_q);
      empty_vec[i] = in_use[i] && !rd_valid[i];
    end
    found = |hit_vec;
    empty = |empty_vec;

    hit_way   = '0;
    empty_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i])   hit_way   = RANK_W'(i);
      if (empty_vec[i]) empty_way = RANK_W'(i);
    end

    // oldest way, lowest index on ties
    best_rank  = '0;
    victim_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && (rd_rank[i] > best_rank)) begin
        best_rank  = rd_rank[i];
        victim_way = RANK_W'(i);
      end
    end

    way_sel  = found ? hit_way : (empty ? empty_way : victim_way);
    old_rank = found ? {1'b0, rd_rank[hit_way]} : (RANK_W + 1)'(MAX_WAYS);

    new_valid = rd_valid;
    new_tag   = rd_tag;
    new_rank  = rd_rank;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && rd_valid[i] && ({1'b0, rd_rank[i]} < old_rank) &&
          (rd_rank[i] < RANK_W'(MAX_WAYS - 1))) begin
        new_rank[i] = rd_rank[i] + RANK_W'(1);
      end
    end
    new_rank[way_sel] = '0;
    if (!found) begin
      new_valid[way_sel] = 1'b1;
      new_tag[way_sel]   = tag_q;
    end
  end

  // running totals
  logic [TOTAL_W-1:0] hits_seen;
  logic [TOTAL_W-1:0] misses_seen;
  logic [TOTAL_W-1:0] evictions_seen;
  logic [TOTAL_W-1:0] hits_seen_next;
  logic [TOTAL_W-1:0] misses_seen_next;
  logic [TOTAL_W-1:0] evictions_seen_next;

  assign modify              = (req_q.kind == KIND_MODIFY);
  assign hits_seen_next      = sat_inc(sat_inc(hits_seen, found || modify), found && modify);
  assign misses_seen_next    = sat_inc(misses_seen, !found);
  assign evictions_seen_next = sat_inc(evictions_seen, !found && !empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else if (cmd.commit) begin
      hits_seen      <= hits_seen_next;
      misses_seen    <= misses_seen_next;
      evictions_seen <= evictions_seen_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.hit            <= found || modify;
      rsp.miss           <= !found;
      rsp.eviction       <= !found && !empty;
      rsp.hit_total      <= hits_seen_next;
      rsp.miss_total     <= misses_seen_next;
      rsp.eviction_total <= evictions_seen_next;
    end
  end

endmodule

[design/set_assoc_lru_cache_model.sv]
// Set-associative cache hit/miss model with true LRU replacement. Each request
// carries a kind (load, store, modify) and a byte address; the address is cut
// into offset, set index and tag by the configured bit counts, and one response
// per request reports hit, miss and eviction plus saturating 32-bit running
// totals (a modify counts one extra hit). Each request passes a read state,
// which reads the set row from the set memories, and a write state, which
// compares tags, picks the way and writes the row back; the next request is
// taken in that write state, so the read-modify-write of the set row limits
// the rate. A response still held by the consumer stalls the write state.
// After reset the block clears the valid bits of all 2**MAX_SET_BITS sets,
// one set per cycle, with req_ready low; configuration writes are taken at
// any time, but are meant to be issued only while no request is in flight.
module set_assoc_lru_cache_model
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,  // sets = 2**MAX_SET_BITS, 0..12
  parameter int MAX_WAYS     = 8   // lines per set, 1..32
) (
  input  logic                   clk,
  input  logic                   rst,
  // access requests
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  // per-access responses
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp,
  // register writes: 0 set_index_bits, 1 offset_bits, 2 ways_in_use
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Controller: clear pass, request intake, read and write-back sequencing.
  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: config, address split, set memories, LRU update, totals,
  // response register.
  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[design/salc_check.sv]
`include "set_assoc_lru_cache_model_macros.svh"

module salc_check
  import salc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // held response stays put
  `SALC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // one request at a time: no intake in the cycle after one is taken
  `SALC_ASSERT_NXT(a_one_inflight, req_valid && req_ready, !req_ready, "request taken while one is in flight")

  // with the response slot empty, a taken request goes through the read and write states and its response is then valid
  `SALC_ASSERT_NXT(a_rsp_latency, req_valid && req_ready && !rsp_valid, ##2 rsp_valid, "response late")

endmodule

bind set_assoc_lru_cache_model salc_check u_check (.*);

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  // Geometry of the instance; the reference behavior is fixed at these sizes.
  localparam int SET_BITS_CAP = 6;
  localparam int WAY_COUNT    = 8;
  localparam int LINE_COUNT   = (1 << SET_BITS_CAP) * WAY_COUNT;

  // Access kinds not named in the package. The spare code behaves as a load.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int PHASES           = 10;
  localparam int ITEMS_PER_PHASE  = 193;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  req_t                   req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  rsp_t                   rsp;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  set_assoc_lru_cache_model #(
    .MAX_SET_BITS(SET_BITS_CAP),
    .MAX_WAYS    (WAY_COUNT)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache: registers, line store, LRU ranks, totals.
  // ---------------------------------------------------------------------------
  logic [SIB_W-1:0]        cfg_set_bits;
  logic [OFFSET_W-1:0]     cfg_offset;
  logic [WAYS_W-1:0]       cfg_ways;

  bit                      line_live [LINE_COUNT];
  logic [ADDRESS_BITS-1:0] line_tag_mem [LINE_COUNT];
  int unsigned             line_age [LINE_COUNT];
  logic [TOTAL_W-1:0]      shadow_hits;
  logic [TOTAL_W-1:0]      shadow_misses;
  logic [TOTAL_W-1:0]      evict_count;

  // Responses owed by the block, oldest first.
  rsp_t                    results_due [$];
  int                      mismatches;

  // Directed rows may carry a hand-written response; it replaces the
  // predicted one for that request (the shadow state still advances).
  bit                      pinned;
  rsp_t                    pinned_rsp;

  // Idle behavior of each side, changed per phase.
  bit                      sender_idles;
  bit                      receiver_idles;

  function automatic logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
    return (v == TOTAL_MAX) ? v : v + 1'b1;
  endfunction

  // Way becomes most recent; valid lines younger than old_rank age by one,
  // ranks stop at WAY_COUNT-1.
  function automatic void promote_way(int unsigned base, int unsigned ways,
                                      int unsigned way, int unsigned old_rank);
    int unsigned k;
    for (int unsigned i = 0; i < ways; i++) begin
      k = base + i;
      if (i != way && line_live[k] && line_age[k] < old_rank &&
          line_age[k] < WAY_COUNT - 1)
        line_age[k] = line_age[k] + 1;
    end
    line_age[base + way] = 0;
  endfunction

  // Lookup plus fill/evict for one accepted request; returns the response.
  function automatic rsp_t predict_access(req_t r);
    int unsigned       s;
    int unsigned       ways;
    int unsigned       set_no;
    int unsigned       base;
    int unsigned       way;
    int unsigned       best;
    int unsigned       tag_shift;
    logic [ADDRESS_BITS-1:0] tag;
    bit                found;
    bit                empty;
    rsp_t              o;
    s = (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : cfg_set_bits;
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_COUNT) ? WAY_COUNT : cfg_ways);
    set_no = 32'((r.address >> cfg_offset) & ((64'd1 << s) - 64'd1));
    tag_shift = cfg_offset + s;
    tag = (tag_shift >= ADDRESS_BITS) ? '0 : (r.address >> tag_shift);
    base = set_no * WAY_COUNT;
    o = '0;
    found = 0;
    way = 0;
    for (int unsigned i = 0; i < ways && !found; i++) begin
      if (line_live[base + i] && line_tag_mem[base + i] == tag) begin
        found = 1;
        way = i;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      shadow_hits = bump(shadow_hits);
      if (r.kind == KIND_MODIFY) shadow_hits = bump(shadow_hits);
      promote_way(base, ways, way, line_age[base + way]);
    end else begin
      o.miss = 1'b1;
      shadow_misses = bump(shadow_misses);
      // the store half of a modify always lands on the freshly filled line
      if (r.kind == KIND_MODIFY) begin
        o.hit = 1'b1;
        shadow_hits = bump(shadow_hits);
      end
      empty = 0;
      for (int unsigned i = 0; i < ways && !empty; i++) begin
        if (!line_live[base + i]) begin
          empty = 1;
          way = i;
        end
      end
      if (!empty) begin
        // oldest rank wins, lowest way on ties
        o.eviction = 1'b1;
        evict_count = bump(evict_count);
        way = 0;
        best = 0;
        for (int unsigned i = 0; i < ways; i++) begin
          if (line_age[base + i] > best) begin
            best = line_age[base + i];
            way = i;
          end
        end
      end
      line_live[base + way] = 1;
      line_tag_mem[base + way] = tag;
      promote_way(base, ways, way, WAY_COUNT);
    end
    o.hit_total      = shadow_hits;
    o.miss_total     = shadow_misses;
    o.eviction_total = evict_count;
    return o;
  endfunction

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slowest legal run is roughly 2k requests at the longest gaps and stalls;
  // this is several times that, plus the clearing pass after reset.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: everything sampled at the rising edge. Register writes update
  // the shadow config, responses are checked against the oldest expectation,
  // accepted requests are run through the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (rst) begin
      cfg_set_bits = '0;
      cfg_offset   = '0;
      cfg_ways     = WAYS_W'(1);
      for (int i = 0; i < LINE_COUNT; i++) begin
        line_live[i]    = 0;
        line_tag_mem[i] = '0;
        line_age[i]     = 0;
      end
      shadow_hits   = '0;
      shadow_misses = '0;
      evict_count   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_INDEX_BITS: cfg_set_bits = cfg_data[SIB_W-1:0];
          CFG_OFFSET_BITS:    cfg_offset   = cfg_data[OFFSET_W-1:0];
          CFG_WAYS_IN_USE:    cfg_ways     = cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        end else begin
          want = results_due.pop_front();
          if (rsp.hit !== want.hit) flag("hit", 64'(want.hit), 64'(rsp.hit));
          if (rsp.miss !== want.miss) flag("miss", 64'(want.miss), 64'(rsp.miss));
          if (rsp.eviction !== want.eviction)
            flag("eviction", 64'(want.eviction), 64'(rsp.eviction));
          if (rsp.hit_total !== want.hit_total)
            flag("hit_total", 64'(want.hit_total), 64'(rsp.hit_total));
          if (rsp.miss_total !== want.miss_total)
            flag("miss_total", 64'(want.miss_total), 64'(rsp.miss_total));
          if (rsp.eviction_total !== want.eviction_total)
            flag("eviction_total", 64'(want.eviction_total), 64'(rsp.eviction_total));
        end
      end
      if (req_valid && req_ready) begin
        want = predict_access(req);
        if (pinned) want = pinned_rsp;
        results_due.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: per response, hold ready low at random (never in quiet
  // phases), then keep it high until a response is taken.
  // ---------------------------------------------------------------------------
  initial begin : response_sink
    int stall;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = receiver_idles ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_valid && rsp_ready)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------
  // One request: optional gap, then valid held with a stable payload until taken.
  task automatic issue(req_t r, bit pin, rsp_t want);
    int gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned     = pin;
    pinned_rsp = want;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed response has come back.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan: register writes and requests in order.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    req_t                  access;
    bit                    pin;
    rsp_t                  want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void add_setting(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row = '{reg_sel: CFG_SET_INDEX_BITS, default: '0};
    row.is_cfg  = 1;
    row.reg_sel = sel;
    row.value   = value;
    plan.push_back(row);
  endfunction

  function automatic void add_access(logic [KIND_W-1:0] kind,
                                     logic [ADDRESS_BITS-1:0] address,
                                     bit pin, rsp_t want);
    plan_row_t row;
    row = '{reg_sel: CFG_SET_INDEX_BITS, default: '0};
    row.reg_sel        = CFG_SET_INDEX_BITS;
    row.access.kind    = kind;
    row.access.address = address;
    row.pin            = pin;
    row.want           = want;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SIB_W-1:0]        sib_v;
    logic [OFFSET_W-1:0]     off_v;
    logic [WAYS_W-1:0]       ways_v;
    int unsigned             s_eff;
    int unsigned             w_eff;
    int unsigned             set_span;
    int unsigned             set_pick;
    logic [ADDRESS_BITS-1:0] low_mask;
    logic [ADDRESS_BITS-1:0] addr;
    logic [ADDRESS_BITS-1:0] tag_pool [12];
    logic [KIND_W-1:0]       kind;
    req_t                    r;

    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SET_INDEX_BITS;
    cfg_data       = '0;
    pinned         = 0;
    pinned_rsp     = '0;
    mismatches     = 0;
    sender_idles   = 1;
    receiver_idles = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset config: one set, one way, tag is the whole address, so every row
    // here can be worked out by hand. Fields: hit miss evict, then totals.
    add_access(KIND_LOAD, 64'h0, 1, rsp_t'({3'b010, 32'd0, 32'd1, 32'd0}));
    add_access(KIND_LOAD, 64'h0, 1, rsp_t'({3'b100, 32'd1, 32'd1, 32'd0}));
    add_access(KIND_STORE, '1, 1, rsp_t'({3'b011, 32'd1, 32'd2, 32'd1}));
    // modify hit counts twice
    add_access(KIND_MODIFY, '1, 1, rsp_t'({3'b100, 32'd3, 32'd2, 32'd1}));
    // modify miss: evicts, store half still hits
    add_access(KIND_MODIFY, 64'h1, 1, rsp_t'({3'b111, 32'd4, 32'd3, 32'd2}));
    // spare kind acts as a load
    add_access(KIND_SPARE, 64'h1, 1, rsp_t'({3'b100, 32'd5, 32'd3, 32'd2}));
    add_access(KIND_STORE, 64'h1, 1, rsp_t'({3'b100, 32'd6, 32'd3, 32'd2}));
    add_access(KIND_LOAD, 64'h8000_0000_0000_0000, 1,
               rsp_t'({3'b011, 32'd6, 32'd4, 32'd3}));

    // Full geometry: fill all eight ways of set 5, then force an LRU eviction,
    // refresh one line and make sure the next victim skips it.
    add_setting(CFG_SET_INDEX_BITS, 6'd6);
    add_setting(CFG_OFFSET_BITS, 6'd4);
    add_setting(CFG_WAYS_IN_USE, 6'd8);
    for (int t = 0; t < 9; t++)
      add_access((t % 2) ? KIND_STORE : KIND_LOAD,
                 (64'(t) << 10) | (64'd5 << 4) | 64'(t), 0, '0);
    add_access(KIND_LOAD, (64'd1 << 10) | (64'd5 << 4), 0, '0);
    add_access(KIND_MODIFY, (64'd0 << 10) | (64'd5 << 4), 0, '0);

    // Out-of-range registers: set bits clamp, offset pushes the tag away,
    // zero ways acts as one. Lines from before stay where they are.
    add_setting(CFG_SET_INDEX_BITS, 6'd7);
    add_setting(CFG_OFFSET_BITS, 6'd63);
    add_setting(CFG_WAYS_IN_USE, 6'd0);
    add_access(KIND_LOAD, '1, 0, '0);
    add_access(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0);
    add_access(KIND_MODIFY, '1, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        issue(plan[i].access, plan[i].pin, plan[i].want);
      end
    end

    // Random phases. Each starts from an idle block (which also gives the
    // pause-until-drained pressure), writes all three registers, then sends
    // requests whose tags come from a small pool so hits, refills and
    // evictions all show up. A tenth of the requests are fully random.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin sib_v = 3'd0; off_v = 6'd0;  ways_v = 4'd1;  end
        1: begin sib_v = 3'd6; off_v = 6'd32; ways_v = 4'd8;  end
        2: begin sib_v = 3'd7; off_v = 6'd63; ways_v = 4'd15; end
        3: begin sib_v = 3'd0; off_v = 6'd63; ways_v = 4'd0;  end
        default: begin
          sib_v  = SIB_W'($urandom_range(0, 7));
          off_v  = OFFSET_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 8));
          ways_v = WAYS_W'($urandom_range(0, 15));
        end
      endcase
      // upper data bits beyond a register's width are don't-care
      write_reg(CFG_SET_INDEX_BITS, {3'($urandom), sib_v});
      write_reg(CFG_OFFSET_BITS, off_v);
      write_reg(CFG_WAYS_IN_USE, {2'($urandom), ways_v});

      sender_idles   = (p % 4) < 2;
      receiver_idles = (p % 2) == 0;

      s_eff    = (sib_v > SET_BITS_CAP) ? SET_BITS_CAP : sib_v;
      w_eff    = (ways_v == 0) ? 1 : ((ways_v > WAY_COUNT) ? WAY_COUNT : ways_v);
      set_span = 1 << s_eff;
      low_mask = (64'd1 << off_v) - 64'd1;
      for (int i = 0; i < 12; i++)
        tag_pool[i] = (i < 6) ? 64'(i) : {$urandom, $urandom};

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          // mostly a handful of sets so lines collide
          set_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, set_span - 1)
                   : $urandom_range(0, ((set_span < 4) ? set_span : 4) - 1);
          addr = ({$urandom, $urandom} & low_mask) | (64'(set_pick) << off_v);
          if (off_v + s_eff < ADDRESS_BITS)
            addr = addr | (tag_pool[$urandom_range(0, w_eff + 2)] << (off_v + s_eff));
        end
        kind = ($urandom_range(0, 15) == 0) ? KIND_SPARE : KIND_W'($urandom_range(0, 2));
        r.kind    = kind;
        r.address = addr;
        issue(r, 0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
